// ----- src/ppsa_pkg.sv -----
// Package for the polygon point side and area block.
// Holds the command and side codes, result field widths and parameter defaults.
// No dependencies; imported by polygon_point_side_and_area.
package ppsa_pkg;

  // Default sizes of the vertex table and of one coordinate.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 24;

  // Widths of the running area sum and of the reported area.
  localparam int SUM_W  = 57;
  localparam int AREA_W = 56;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Side codes of a result item.
  typedef enum logic [1:0] {
    SIDE_OUT  = 2'd0,
    SIDE_IN   = 2'd1,
    SIDE_EDGE = 2'd2
  } side_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_APPEND = 6'b001000,
    ST_ACCUM  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage

// ----- src/polygon_point_side_and_area.sv -----
// Polygon vertex table with point-in-polygon classification and doubled area.
// Holds the vertex memory, the edge walk pipeline and the shared cross product unit.
// Depends on ppsa_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries a command and a point.
// A clear empties the polygon, an append stores the point as the next vertex,
// and a query classifies the point as outside, inside or on the boundary.
// Every transfer on the input channel yields exactly one transfer on the result
// channel (out_valid/out_ready) with the side, twice the absolute area, the
// vertex count and an overflow flag for an append that found the table full.
// A clear, an ignored command or a dropped append goes straight to the finish
// state; a stored append passes through the append state (the shared multiplier
// forms the fan cross product) and the accumulate state (the sum is updated). A
// query walks the edges, reading one vertex per cycle from the single memory read
// port and classifies one edge per cycle through a two-stage multiply and compare.
// One item is in work at a time; in_ready is high whenever the sequencer is
// idle, also while a finished result waits in the output register. When the
// receiver stalls, a finished item waits in the sequencer until the output
// register frees. Reset empties the polygon and the area sum; the vertex
// memory is not cleared, since only entries written since the last clear are read.
module polygon_point_side_and_area
  import ppsa_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_cmd,
  input  logic signed [COORD_BITS-1:0]          in_x,
  input  logic signed [COORD_BITS-1:0]          in_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_side,
  output logic [AREA_W-1:0]                     out_twice_area,
  output logic [$clog2(MAX_VERTICES+1)-1:0]     out_vertex_count,
  output logic                                  out_overflow
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CW    = PW + 1;
  localparam int EXT_W = (CW > SUM_W) ? CW : SUM_W;

  // Sequencer and polygon state.
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [SUM_W-1:0]         sum_r;
  logic [CNT_W-1:0]         issue_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [COORD_BITS-1:0] v0x_r, v0y_r, lastx_r, lasty_r;
  logic signed [COORD_BITS-1:0] curx_r, cury_r;

  // Vertex memory, packed as {x, y}.
  logic [2*COORD_BITS-1:0]  vtx_mem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0]  rd_r;
  logic [AW-1:0]            rd_addr;
  logic                     wrap_now;

  // Edge pipeline.
  logic                     s1_v_r, s1_wrap_r;
  logic                     s2_v_r, s2_last_r, s2_hit_r, s2_flip_r, s2_orient_r;
  logic signed [PW-1:0]     prod_p_r, prod_q_r;
  logic                     inside_r, edge_r;
  logic                     inside_upd, edge_upd;

  // Pending result and output register.
  side_t                    res_side_r;
  logic                     res_ovf_r;
  logic                     out_valid_r;
  logic [1:0]               out_side_r;
  logic [AREA_W-1:0]        out_area_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_ovf_r;

  logic in_xfer, full, out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (cnt_r == CNT_W'(MAX_VERTICES));
  assign out_free = !out_valid_r || out_ready;

  // Next vertex of the current edge: from memory, or the first vertex on wrap.
  logic signed [COORD_BITS-1:0] nx, ny;
  assign nx = s1_wrap_r ? v0x_r : rd_r[2*COORD_BITS-1:COORD_BITS];
  assign ny = s1_wrap_r ? v0y_r : rd_r[COORD_BITS-1:0];

  // Edge classification against the query point.
  logic below, above, nhit, cls_hit, cls_flip, cls_orient;
  always_comb begin
    below      = (cury_r < py_r);
    above      = (cury_r > py_r);
    nhit       = (ny == py_r) && (nx == px_r);
    cls_hit    = 1'b0;
    cls_flip   = 1'b0;
    cls_orient = 1'b0;
    if (below) begin
      cls_hit    = nhit;
      cls_orient = !nhit && (ny > py_r);
    end else if (above) begin
      cls_hit    = nhit;
      cls_orient = !nhit && (ny < py_r);
    end else if (px_r == curx_r) begin
      cls_hit = 1'b1;
    end else if (ny == py_r) begin
      cls_hit = ((px_r > curx_r) && (px_r <= nx)) || ((px_r < curx_r) && (px_r >= nx));
    end else begin
      cls_flip = (px_r < curx_r);
    end
  end

  // Shared cross product unit: (b - a) x (c - a) as two products.
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
  logic signed [DW-1:0]         d1, d2, d3, d4;
  logic signed [PW-1:0]         prod_p_nxt, prod_q_nxt;
  always_comb begin
    if (s1_v_r) begin
      bx = px_r;
      by = py_r;
      if (below) begin
        ax = curx_r; ay = cury_r; cx = nx; cy = ny;
      end else begin
        ax = nx; ay = ny; cx = curx_r; cy = cury_r;
      end
    end else begin
      ax = v0x_r;   ay = v0y_r;
      bx = lastx_r; by = lasty_r;
      cx = px_r;    cy = py_r;
    end
    d1 = DW'(bx) - DW'(ax);
    d2 = DW'(cy) - DW'(ay);
    d3 = DW'(by) - DW'(ay);
    d4 = DW'(cx) - DW'(ax);
    prod_p_nxt = d1 * d2;
    prod_q_nxt = d3 * d4;
  end

  // Cross product and area magnitude.
  logic signed [CW-1:0]    cross_w;
  logic signed [EXT_W-1:0] cross_ext;
  logic [SUM_W-1:0]        mag;
  assign cross_w   = prod_p_r - prod_q_r;
  assign cross_ext = EXT_W'(cross_w);
  assign mag       = sum_r[SUM_W-1] ? (SUM_W'(0) - sum_r) : sum_r;

  // Edge verdict after the compare stage.
  assign edge_upd   = edge_r | (s2_v_r & (s2_hit_r | (s2_orient_r & (prod_p_r == prod_q_r))));
  assign inside_upd = inside_r ^ (s2_v_r & (s2_flip_r | (s2_orient_r & (prod_p_r < prod_q_r))));

  // Memory read address; the wrap edge reads nothing useful.
  assign wrap_now = (issue_r == cnt_r);
  assign rd_addr  = wrap_now ? '0 : issue_r[AW-1:0];

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (cmd_t'(in_cmd))
            CMD_APPEND: state_nxt = full ? ST_FINISH : ST_APPEND;
            CMD_QUERY:  state_nxt = (cnt_r == '0) ? ST_FINISH : ST_WALK;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_WALK:   if (wrap_now) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (s2_v_r && s2_last_r) state_nxt = ST_FINISH;
      ST_APPEND: state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == ST_WALK);
      s2_v_r  <= s1_v_r;
      if (in_xfer && (cmd_t'(in_cmd) == CMD_CLEAR)) begin
        cnt_r <= '0;
        sum_r <= '0;
      end else if (in_xfer && (cmd_t'(in_cmd) == CMD_APPEND) && !full) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if ((state_r == ST_ACCUM) && (cnt_r >= CNT_W'(3))) begin
        sum_r <= sum_r + cross_ext[SUM_W-1:0];
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Vertex memory write and registered read.
  always_ff @(posedge clk) begin
    if (in_xfer && (cmd_t'(in_cmd) == CMD_APPEND) && !full) begin
      vtx_mem[cnt_r[AW-1:0]] <= {in_x, in_y};
    end
    if (state_r == ST_WALK) begin
      rd_r <= vtx_mem[rd_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r       <= in_x;
      py_r       <= in_y;
      res_side_r <= SIDE_OUT;
      res_ovf_r  <= (cmd_t'(in_cmd) == CMD_APPEND) && full;
      issue_r    <= CNT_W'(1);
      curx_r     <= v0x_r;
      cury_r     <= v0y_r;
      inside_r   <= 1'b0;
      edge_r     <= 1'b0;
      if ((cmd_t'(in_cmd) == CMD_APPEND) && (cnt_r == '0)) begin
        v0x_r <= in_x;
        v0y_r <= in_y;
      end
    end
    // Walk: issue one vertex address per cycle.
    if (state_r == ST_WALK) begin
      issue_r   <= issue_r + CNT_W'(1);
      s1_wrap_r <= wrap_now;
    end
    // Classify stage: flags and products, and the edge moves on.
    if (s1_v_r) begin
      curx_r      <= nx;
      cury_r      <= ny;
      s2_last_r   <= s1_wrap_r;
      s2_hit_r    <= cls_hit;
      s2_flip_r   <= cls_flip;
      s2_orient_r <= cls_orient;
    end
    if (s1_v_r || (state_r == ST_APPEND)) begin
      prod_p_r <= prod_p_nxt;
      prod_q_r <= prod_q_nxt;
    end
    // Compare stage: fold the edge into the verdict.
    if (s2_v_r) begin
      edge_r   <= edge_upd;
      inside_r <= inside_upd;
      if (s2_last_r) begin
        res_side_r <= edge_upd ? SIDE_EDGE : (inside_upd ? SIDE_IN : SIDE_OUT);
      end
    end
    // The appended vertex becomes the last one once its fan product is used.
    if (state_r == ST_ACCUM) begin
      lastx_r <= px_r;
      lasty_r <= py_r;
    end
    // Load the output register.
    if (state_r == ST_FINISH && out_free) begin
      out_side_r <= res_side_r;
      out_area_r <= mag[AREA_W-1:0];
      out_cnt_r  <= cnt_r;
      out_ovf_r  <= res_ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_side         = out_side_r;
  assign out_twice_area   = out_area_r;
  assign out_vertex_count = out_cnt_r;
  assign out_overflow     = out_ovf_r;

  // The stored count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table size");

  // The edge pipeline is empty whenever a new item can be taken.
  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!s1_v_r && !s2_v_r))
    else $error("edge pipeline busy while idle");

  // A dropped append is reported only with a full table.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_vertex_count == CNT_W'(MAX_VERTICES)))
    else $error("overflow reported with room left");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for polygon_point_side_and_area: a predictor tracks the
// vertex table and area sum and checks every result transfer in order.
// Depends on ppsa_pkg and polygon_point_side_and_area.
module tb;
  import ppsa_pkg::*;

  localparam int MAX_V        = MAX_VERTICES_DEF;
  localparam int CW           = COORD_BITS_DEF;
  localparam int VC_W         = $clog2(MAX_V + 1);
  localparam int GAP_MAX      = 18;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 500;
  localparam int TAIL_CYCLES  = 80;
  localparam int PRINT_MAX    = 50;
  localparam longint C_MAX    = 64'sd8388607;
  localparam longint C_MIN    = -64'sd8388608;

  typedef struct {
    cmd_t                 cmd;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } poly_item_t;

  typedef struct {
    side_t             side;
    logic [AREA_W-1:0] twice_area;
    logic [VC_W-1:0]   vertex_count;
    logic              overflow;
  } poly_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = '0;
  logic signed [CW-1:0] in_x = '0;
  logic signed [CW-1:0] in_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_side;
  logic [AREA_W-1:0]    out_twice_area;
  logic [VC_W-1:0]      out_vertex_count;
  logic                 out_overflow;

  // Items waiting to be driven and results waiting to be seen.
  poly_item_t   pending_items[$];
  poly_result_t expected_results[$];

  // Predicted polygon state.
  longint           poly_x[MAX_V];
  longint           poly_y[MAX_V];
  int               poly_count = 0;
  logic [SUM_W-1:0] area_sum = '0;

  // Generator's own view of the vertex list, used to aim queries.
  longint gen_x[MAX_V];
  longint gen_y[MAX_V];
  int     gen_n = 0;

  // Handshake flags sampled at the rising edge, read at the falling edge.
  bit in_xfer = 1'b0;
  bit out_xfer = 1'b0;
  int results_seen = 0;
  int error_count = 0;
  int idle_cycles = 0;

  // Sender and receiver pacing.
  int in_gap = 0;
  int sent_count = 0;
  bit in_burst = 1'b0;
  int out_wait = 0;
  int hold_left = 0;
  bit out_burst = 1'b0;

  polygon_point_side_and_area dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_x            (in_x),
    .in_y            (in_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_side        (out_side),
    .out_twice_area  (out_twice_area),
    .out_vertex_count(out_vertex_count),
    .out_overflow    (out_overflow)
  );

  always #5 clk = ~clk;

  // Sign of the cross product (b - a) x (c - a).
  function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                   longint cx, longint cy);
    longint p;
    longint q;
    p = (bx - ax) * (cy - ay);
    q = (by - ay) * (cx - ax);
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  // Crossing-parity walk over every edge, closing the ring at the first vertex.
  function automatic side_t point_side(longint px, longint py);
    logic   odd;
    int     i;
    int     j;
    int     s;
    longint cx, cy, nx, ny;
    odd = 1'b0;
    for (i = 0; i < poly_count; i++) begin
      j = (i + 1 < poly_count) ? i + 1 : 0;
      cx = poly_x[i];
      cy = poly_y[i];
      nx = poly_x[j];
      ny = poly_y[j];
      if (cy < py) begin
        if (ny == py && nx == px) return SIDE_EDGE;
        if (ny > py) begin
          s = turn_sign(cx, cy, px, py, nx, ny);
          if (s == 0) return SIDE_EDGE;
          if (s < 0) odd = !odd;
        end
      end else if (cy > py) begin
        if (ny == py && nx == px) return SIDE_EDGE;
        if (ny < py) begin
          s = turn_sign(nx, ny, px, py, cx, cy);
          if (s == 0) return SIDE_EDGE;
          if (s < 0) odd = !odd;
        end
      end else begin
        // The edge starts on the query row.
        if (px == cx) return SIDE_EDGE;
        if (ny == py) begin
          if ((px > cx && px <= nx) || (px < cx && px >= nx)) return SIDE_EDGE;
        end else if (px < cx) begin
          odd = !odd;
        end
      end
    end
    return odd ? SIDE_IN : SIDE_OUT;
  endfunction

  // Applies one accepted item to the predicted state and returns its result.
  function automatic poly_result_t apply_item(poly_item_t it);
    poly_result_t     r;
    longint           px, py, fan_cross;
    logic [SUM_W-1:0] mag;
    px = it.x;
    py = it.y;
    r.side = SIDE_OUT;
    r.overflow = 1'b0;
    case (it.cmd)
      CMD_CLEAR: begin
        poly_count = 0;
        area_sum = '0;
      end
      CMD_APPEND: begin
        if (poly_count >= MAX_V) begin
          r.overflow = 1'b1;
        end else begin
          poly_x[poly_count] = px;
          poly_y[poly_count] = py;
          // Fan triangle from the first vertex over the newest edge.
          if (poly_count >= 2) begin
            fan_cross = (poly_x[poly_count-1] - poly_x[0]) * (py - poly_y[0]) -
                        (poly_y[poly_count-1] - poly_y[0]) * (px - poly_x[0]);
            area_sum = area_sum + SUM_W'(fan_cross);
          end
          poly_count++;
        end
      end
      CMD_QUERY: r.side = point_side(px, py);
      default: ;
    endcase
    mag = area_sum[SUM_W-1] ? -area_sum : area_sum;
    r.twice_area = mag[AREA_W-1:0];
    r.vertex_count = VC_W'(poly_count);
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < PRINT_MAX) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Queues one item and keeps the generator's vertex list in step.
  task automatic push_item(cmd_t c, longint x, longint y);
    poly_item_t it;
    it.cmd = c;
    it.x = CW'(x);
    it.y = CW'(y);
    pending_items = {pending_items, it};
    if (c == CMD_CLEAR) begin
      gen_n = 0;
    end else if (c == CMD_APPEND && gen_n < MAX_V) begin
      gen_x[gen_n] = longint'(it.x);
      gen_y[gen_n] = longint'(it.y);
      gen_n++;
    end
  endtask

  // Coordinate styles: a small grid, a coarse grid over the full range, anything.
  function automatic longint rand_coord(int style);
    case (style)
      0: return longint'(int'($urandom_range(0, 12)) - 6);
      1: return longint'(int'($urandom_range(0, 15)) - 8) * (longint'(1) << 20);
      default: return longint'($signed(CW'($urandom)));
    endcase
  endfunction

  // Stimulus: directed items first, then random polygons with aimed queries.
  initial begin
    int     style, nverts, nq, qk, i, j, k;
    bit     first;
    longint qx, qy;

    // Empty polygon, unused command, one and two vertices.
    push_item(CMD_QUERY, 5, 5);
    push_item(CMD_NONE, -1, -1);
    push_item(CMD_APPEND, C_MAX, C_MAX);
    push_item(CMD_QUERY, C_MAX, C_MAX);
    push_item(CMD_QUERY, 0, 0);
    push_item(CMD_APPEND, C_MIN, C_MIN);
    push_item(CMD_QUERY, -1, -1);
    push_item(CMD_QUERY, 0, 1);
    // Square spanning the whole coordinate range.
    push_item(CMD_CLEAR, 0, 0);
    push_item(CMD_APPEND, C_MIN, C_MIN);
    push_item(CMD_APPEND, C_MAX, C_MIN);
    push_item(CMD_APPEND, C_MAX, C_MAX);
    push_item(CMD_APPEND, C_MIN, C_MAX);
    push_item(CMD_QUERY, 0, 0);
    push_item(CMD_QUERY, C_MIN, 5);
    push_item(CMD_QUERY, 3, C_MIN);
    // Triangle with a horizontal base.
    push_item(CMD_CLEAR, C_MAX, C_MIN);
    push_item(CMD_APPEND, 0, 0);
    push_item(CMD_APPEND, 8, 0);
    push_item(CMD_APPEND, 4, 8);
    push_item(CMD_QUERY, 4, 4);
    push_item(CMD_QUERY, 4, 0);
    push_item(CMD_QUERY, -3, 0);
    push_item(CMD_QUERY, 6, 4);
    push_item(CMD_QUERY, 9, 8);

    // Random polygons; the first one overfills the table.
    first = 1'b1;
    k = pending_items.size() + RANDOM_ITEMS;
    while (pending_items.size() < k) begin
      if (!first && $urandom_range(0, 19) == 0) begin
        push_item(cmd_t'($urandom_range(0, 3)), rand_coord(2), rand_coord(2));
      end else begin
        style = $urandom_range(0, 2);
        if (first || $urandom_range(0, 7) != 0) push_item(CMD_CLEAR, rand_coord(2), rand_coord(2));
        if (first) nverts = MAX_V + 2;
        else if ($urandom_range(0, 11) == 0) nverts = $urandom_range(MAX_V - 4, MAX_V + 6);
        else nverts = $urandom_range(0, 8);
        first = 1'b0;
        repeat (nverts) push_item(CMD_APPEND, rand_coord(style), rand_coord(style));
        nq = $urandom_range(1, 6);
        repeat (nq) begin
          qk = $urandom_range(0, 4);
          qx = rand_coord(style);
          qy = rand_coord(style);
          if (gen_n > 0 && qk != 4) begin
            i = $urandom_range(0, gen_n - 1);
            j = (i + 1 < gen_n) ? i + 1 : 0;
            case (qk)
              0: begin
                qx = gen_x[i];
                qy = gen_y[i];
              end
              1: begin
                qx = (gen_x[i] + gen_x[j]) / 2;
                qy = (gen_y[i] + gen_y[j]) / 2;
              end
              2: begin
                qx = gen_x[i] + longint'(int'($urandom_range(0, 2)) - 1);
                qy = gen_y[$urandom_range(0, gen_n - 1)];
              end
              default: ;
            endcase
          end
          push_item(CMD_QUERY, qx, qy);
        end
      end
    end

    // Synchronous reset, released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain, then keep the clock running for TAIL_CYCLES to let the block misbehave.
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: offers the next item after its drawn gap, holding it until transfer.
  always @(negedge clk) begin
    poly_item_t next_item;
    if (rst_n) begin
      if (in_valid && !in_xfer) begin
        // Still waiting for the transfer.
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_cmd <= next_item.cmd;
        in_x <= next_item.x;
        in_y <= next_item.y;
        sent_count++;
        if (sent_count % 40 == 0) in_burst = ($urandom_range(0, 2) == 0);
        in_gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls a drawn number of cycles per result, and once for a long stretch.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) begin
        if (results_seen % 40 == 0) out_burst = ($urandom_range(0, 2) == 0);
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        out_wait = out_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer.
  always @(posedge clk) begin
    poly_item_t   seen_item;
    poly_result_t want;
    if (!rst_n) begin
      in_xfer = 1'b0;
      out_xfer = 1'b0;
    end else begin
      in_xfer = in_valid && in_ready;
      out_xfer = out_valid && out_ready;
      if (in_xfer) begin
        seen_item.cmd = cmd_t'(in_cmd);
        seen_item.x = in_x;
        seen_item.y = in_y;
        want = apply_item(seen_item);
        expected_results = {expected_results, want};
      end
      if (out_xfer) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (out_side !== want.side)
            report_error($sformatf("result %0d side %0d, expected %0d",
                                   results_seen, out_side, want.side));
          if (out_twice_area !== want.twice_area)
            report_error($sformatf("result %0d twice_area %0h, expected %0h",
                                   results_seen, out_twice_area, want.twice_area));
          if (out_vertex_count !== want.vertex_count)
            report_error($sformatf("result %0d vertex_count %0d, expected %0d",
                                   results_seen, out_vertex_count, want.vertex_count));
          if (out_overflow !== want.overflow)
            report_error($sformatf("result %0d overflow %0b, expected %0b",
                                   results_seen, out_overflow, want.overflow));
        end
      end
      // Watchdog on cycles without any transfer.
      if (in_xfer || out_xfer) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
